// ----- rtl/spqc_pkg.sv -----
// ----------------------------------------------------------------------------
// spqc_pkg
// Shared types and codes for the three-level priority queue with cancel.
// ----------------------------------------------------------------------------
`default_nettype none

package spqc_pkg;

	localparam int ID_W     = 16;
	localparam int LEVEL_W  = 2;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	// operation codes
	localparam logic [OPCODE_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CANCEL  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_FLUSH   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd4;

	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic               enq;    // insert new entry in sorted place
		logic               deq;    // shift everything toward the head
		logic               cancel; // close the gap at the first match
		logic [ID_W-1:0]    id;
		logic [LEVEL_W-1:0] level;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/spqc_req_if.sv -----
// ----------------------------------------------------------------------------
// spqc_req_if
// Request channel: one queue operation with its id and level.
// ----------------------------------------------------------------------------
`default_nettype none

interface spqc_req_if
	import spqc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ID_W-1:0]     entry_id;
	logic [LEVEL_W-1:0]  level;

	modport source (output valid, output opcode, output entry_id, output level, input ready);
	modport sink   (input valid, input opcode, input entry_id, input level, output ready);
endinterface

`default_nettype wire

// ----- rtl/spqc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// spqc_rsp_if
// Response channel: status, dequeued entry and occupancy after the request.
// ----------------------------------------------------------------------------
`default_nettype none

interface spqc_rsp_if
	import spqc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_id;
	logic [LEVEL_W-1:0]  out_level;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output out_id, output out_level,
		output occupancy, input ready);
	modport sink   (input valid, input status, input out_id, input out_level,
		input occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/stable_priority_queue_with_cancel.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_with_cancel
// Bounded three-level priority queue, first-in-first-out within a level,
// built as a row of shifting slot cells kept in service order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    opcode, entry_id, level
//  rsp      out  valid/ready    status, out_id, out_level, occupancy
//
//  all cells compare against an accepted request in parallel and shift on
//  the edge that accepts it; the response is registered
//  reset clears the slot count and the response valid; slot contents are
//  never read beyond the count and have no reset
//  a new request is taken while the response register is empty or being taken
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_with_cancel
	import spqc_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spqc_req_if.sink  req,
	spqc_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;

	cell_ctrl_t ctrl;
	entry_t     cell_data [CAPACITY];
	logic       cell_keep [CAPACITY];
	logic       cell_hit  [CAPACITY];
	logic       found;

	logic [STATUS_W-1:0] status_nxt;
	entry_t              head_nxt;
	logic [CNT_W+OCC_W-1:0] count_wide;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     out_id_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic [OCC_W-1:0]    occupancy_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign found     = cell_hit[CAPACITY-1];

	always_comb begin
		status_nxt = ST_OK;
		count_nxt  = count_q;
		head_nxt   = '{id: '0, level: LEVEL_NONE};
		unique case (req.opcode)
			OP_ENQUEUE: begin
				if (req.level == LEVEL_NONE) begin
					status_nxt = ST_BAD_LEVEL;
				end else if (count_q == CNT_FULL) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CNT_ONE;
				end
			end
			OP_DEQUEUE: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					head_nxt  = cell_data[0];
					count_nxt = count_q - CNT_ONE;
				end
			end
			OP_CANCEL: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else if (!found) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					count_nxt = count_q - CNT_ONE;
				end
			end
			OP_FLUSH: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	always_comb begin
		ctrl.enq    = accept && (req.opcode == OP_ENQUEUE) && (req.level != LEVEL_NONE)
			&& (count_q != CNT_FULL);
		ctrl.deq    = accept && (req.opcode == OP_DEQUEUE) && (count_q != '0);
		ctrl.cancel = accept && (req.opcode == OP_CANCEL);
		ctrl.id     = req.entry_id;
		ctrl.level  = req.level;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic   left_keep;
		entry_t left_data;
		entry_t right_data;
		logic   hit_in;

		if (i == 0) begin : g_head
			assign left_keep = 1'b1;
			assign left_data = cell_data[0];
			assign hit_in    = 1'b0;
		end else begin : g_body
			assign left_keep = cell_keep[i-1];
			assign left_data = cell_data[i-1];
			assign hit_in    = cell_hit[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		spqc_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (IDX < count_q),
			.left_keep  (left_keep),
			.left_data  (left_data),
			.right_data (right_data),
			.hit_in     (hit_in),
			.keep       (cell_keep[i]),
			.hit_out    (cell_hit[i]),
			.data       (cell_data[i])
		);
	end

	// occupancy is the count masked to the field width
	assign count_wide = {{OCC_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			out_id_q    <= head_nxt.id;
			out_level_q <= head_nxt.level;
			occupancy_q <= count_wide[OCC_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_id    = out_id_q;
	assign rsp.out_level = out_level_q;
	assign rsp.occupancy = occupancy_q;

endmodule

`default_nettype wire

// ----- rtl/spqc_cell.sv -----
// ----------------------------------------------------------------------------
// spqc_cell
// One slot of the sorted queue; shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spqc_cell
	import spqc_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       occupied,
	input  wire logic       left_keep,
	input  wire entry_t     left_data,
	input  wire entry_t     right_data,
	input  wire logic       hit_in,
	output logic            keep,
	output logic            hit_out,
	output entry_t          data
);

	entry_t data_q;
	logic   match;

	assign data    = data_q;
	// slot stays put on insert when it is at least as urgent as the new entry
	assign keep    = occupied && (data_q.level <= ctrl.level);
	assign match   = occupied && (data_q.id == ctrl.id);
	assign hit_out = hit_in | match;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				if (left_keep) begin
					data_q <= '{id: ctrl.id, level: ctrl.level};
				end else begin
					data_q <= left_data;
				end
			end
		end else if (ctrl.deq) begin
			data_q <= right_data;
		end else if (ctrl.cancel && hit_out) begin
			data_q <= right_data;
		end
	end

endmodule

`default_nettype wire
